// ===== design/bprg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitplane resolution guesser package
// Shared types, constants and chunk-building functions.
// ----------------------------------------------------------------------------
package bprg_pkg;

    localparam int COUNT_W = 15;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Guessed resolution codes.
    localparam logic [1:0] RES_LOW    = 2'd0;
    localparam logic [1:0] RES_MEDIUM = 2'd1;
    localparam logic [1:0] RES_MONO   = 2'd2;

    // Byte positions inside the eight-byte group that close a plane group.
    localparam logic [2:0] POS_MED_FIRST_END = 3'd3;
    localparam logic [2:0] POS_GROUP_END     = 3'd7;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [3:0][7:0] med_chunks_t;
    typedef logic [7:0][7:0] low_chunks_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] image_byte;
        logic       is_last;
    } bprg_item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] resolution;
        count_t     mono_repeats;
        count_t     medium_repeats;
        count_t     low_repeats;
    } bprg_result_t;

    // Two plane words give four chunky bytes of four 2-bit pixels.
    function automatic med_chunks_t build_medium(input logic [15:0] w1,
                                                 input logic [15:0] w2);
        med_chunks_t ch;
        ch = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                ch[c][7-2*k] = w1[15-4*c-k];
                ch[c][6-2*k] = w2[15-4*c-k];
            end
        end
        return ch;
    endfunction

    // Four plane words give eight chunky bytes of two 4-bit pixels.
    function automatic low_chunks_t build_low(input logic [15:0] w1,
                                              input logic [15:0] w2,
                                              input logic [15:0] w3,
                                              input logic [15:0] w4);
        low_chunks_t ch;
        ch = '0;
        for (int c = 0; c < 8; c++) begin
            for (int k = 0; k < 2; k++) begin
                ch[c][7-4*k] = w1[15-2*c-k];
                ch[c][6-4*k] = w2[15-2*c-k];
                ch[c][5-4*k] = w3[15-2*c-k];
                ch[c][4-4*k] = w4[15-2*c-k];
            end
        end
        return ch;
    endfunction

    function automatic logic [3:0] repeats_medium(input logic [7:0] prev,
                                                  input med_chunks_t ch);
        logic [3:0] n;
        n = (ch[0] == prev) ? 4'd1 : 4'd0;
        for (int i = 1; i < 4; i++) begin
            if (ch[i] == ch[i-1]) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [3:0] repeats_low(input logic [7:0] prev,
                                               input low_chunks_t ch);
        logic [3:0] n;
        n = (ch[0] == prev) ? 4'd1 : 4'd0;
        for (int i = 1; i < 8; i++) begin
            if (ch[i] == ch[i-1]) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    function automatic count_t sat_add(input count_t count, input logic [3:0] inc);
        logic [COUNT_W:0] sum;
        sum = {1'b0, count} + {{(COUNT_W-3){1'b0}}, inc};
        if (sum > {1'b0, COUNT_MAX}) begin
            return COUNT_MAX;
        end
        return sum[COUNT_W-1:0];
    endfunction

endpackage

// ===== design/bprg_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module bprg_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_image_byte,
    input  logic                 s_is_last,
    input  logic                 consume,
    output bprg_pkg::bprg_item_t item
);
    import bprg_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign s_ready    = !valid_reg || consume;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_image_byte;
            last_reg <= s_is_last;
        end
    end

    assign item.valid      = valid_reg;
    assign item.image_byte = byte_reg;
    assign item.is_last    = last_reg;

endmodule

// ===== design/bprg_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeat counting core
// Keeps the per-image state and tallies repeats under the three readings.
// ----------------------------------------------------------------------------
module bprg_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bprg_pkg::bprg_item_t   item,
    input  logic                   out_free,
    output logic                   consume,
    output bprg_pkg::bprg_result_t result
);
    import bprg_pkg::*;

    logic [7:0]  prev_mono_reg,  prev_mono_next;
    logic [7:0]  prev_med_reg,   prev_med_next;
    logic [7:0]  prev_low_reg,   prev_low_next;
    count_t      mono_count_reg, mono_count_next;
    count_t      med_count_reg,  med_count_next;
    count_t      low_count_reg,  low_count_next;
    logic [55:0] group_reg,      group_next;
    logic [2:0]  pos_reg,        pos_next;

    logic [63:0] full;
    med_chunks_t med_chunks;
    low_chunks_t low_chunks;
    count_t      mono_upd, med_upd, low_upd;
    logic [7:0]  prev_mono_upd, prev_med_upd, prev_low_upd;

    // A last item needs the result register free; other items never wait.
    assign consume = item.valid && (!item.is_last || out_free);

    assign full       = {group_reg, item.image_byte};
    assign med_chunks = build_medium(full[31:16], full[15:0]);
    assign low_chunks = build_low(full[63:48], full[47:32], full[31:16], full[15:0]);

    always_comb begin
        mono_upd      = mono_count_reg;
        prev_mono_upd = prev_mono_reg;
        if (item.image_byte == prev_mono_reg) begin
            mono_upd = sat_add(mono_count_reg, 4'd1);
        end else begin
            prev_mono_upd = item.image_byte;
        end

        med_upd      = med_count_reg;
        prev_med_upd = prev_med_reg;
        if (pos_reg inside {POS_MED_FIRST_END, POS_GROUP_END}) begin
            med_upd      = sat_add(med_count_reg, repeats_medium(prev_med_reg, med_chunks));
            prev_med_upd = med_chunks[3];
        end

        low_upd      = low_count_reg;
        prev_low_upd = prev_low_reg;
        if (pos_reg == POS_GROUP_END) begin
            low_upd      = sat_add(low_count_reg, repeats_low(prev_low_reg, low_chunks));
            prev_low_upd = low_chunks[7];
        end
    end

    always_comb begin
        prev_mono_next  = prev_mono_reg;
        prev_med_next   = prev_med_reg;
        prev_low_next   = prev_low_reg;
        mono_count_next = mono_count_reg;
        med_count_next  = med_count_reg;
        low_count_next  = low_count_reg;
        group_next      = group_reg;
        pos_next        = pos_reg;
        if (consume) begin
            if (item.is_last) begin
                // The image is done: start the next one from a clean state.
                prev_mono_next  = '0;
                prev_med_next   = '0;
                prev_low_next   = '0;
                mono_count_next = '0;
                med_count_next  = '0;
                low_count_next  = '0;
                group_next      = '0;
                pos_next        = '0;
            end else begin
                prev_mono_next  = prev_mono_upd;
                prev_med_next   = prev_med_upd;
                prev_low_next   = prev_low_upd;
                mono_count_next = mono_upd;
                med_count_next  = med_upd;
                low_count_next  = low_upd;
                group_next      = full[55:0];
                pos_next        = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mono_reg  <= '0;
            prev_med_reg   <= '0;
            prev_low_reg   <= '0;
            mono_count_reg <= '0;
            med_count_reg  <= '0;
            low_count_reg  <= '0;
            group_reg      <= '0;
            pos_reg        <= '0;
        end else begin
            prev_mono_reg  <= prev_mono_next;
            prev_med_reg   <= prev_med_next;
            prev_low_reg   <= prev_low_next;
            mono_count_reg <= mono_count_next;
            med_count_reg  <= med_count_next;
            low_count_reg  <= low_count_next;
            group_reg      <= group_next;
            pos_reg        <= pos_next;
        end
    end

    always_comb begin
        result.valid          = consume && item.is_last;
        result.mono_repeats   = mono_upd;
        result.medium_repeats = med_upd;
        result.low_repeats    = low_upd;
        if (mono_upd >= low_upd && mono_upd >= med_upd) begin
            result.resolution = RES_MONO;
        end else if (med_upd > low_upd) begin
            result.resolution = RES_MEDIUM;
        end else begin
            result.resolution = RES_LOW;
        end
    end

endmodule

// ===== design/bprg_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module bprg_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bprg_pkg::bprg_result_t result,
    output logic                   out_free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_resolution,
    output logic [14:0]            m_mono_repeats,
    output logic [14:0]            m_medium_repeats,
    output logic [14:0]            m_low_repeats
);
    import bprg_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] res_reg;
    count_t     mono_reg;
    count_t     med_reg;
    count_t     low_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = result.valid ? 1'b1 : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (result.valid) begin
            res_reg  <= result.resolution;
            mono_reg <= result.mono_repeats;
            med_reg  <= result.medium_repeats;
            low_reg  <= result.low_repeats;
        end
    end

    assign m_valid          = valid_reg;
    assign m_resolution     = res_reg;
    assign m_mono_repeats   = mono_reg;
    assign m_medium_repeats = med_reg;
    assign m_low_repeats    = low_reg;

endmodule

// ===== design/bitplane_resolution_guesser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitplane resolution guesser
// Guesses the plane layout of a raw screen image from repeat counts.
// ----------------------------------------------------------------------------
// The input channel carries one raw screen byte per item, in memory order,
// with s_is_last set on the final byte of an image. The result channel carries
// one item per image: the guessed resolution and the three repeat counts.
//
// An accepted item lands in an input register. When the core consumes it, the
// core compares it against the stored state for the mono, two-plane and
// four-plane readings and updates the counts; a group of four or eight bytes
// is unpacked and tallied in that same cycle. On the last byte the result is
// loaded into the result register, which drives m_valid. A last byte waits in
// the input register until the result register is free; otherwise the block
// takes one item per cycle.
//
// Reset (aresetn low at a clock edge) empties both registers and clears all
// counts. After each last item the state clears by itself for the next image.
// When the receiver stalls, ordinary bytes keep flowing; only a last byte
// waits in the input register until the result register is free.
// ----------------------------------------------------------------------------
module bitplane_resolution_guesser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_image_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_resolution,
    output logic [14:0] m_mono_repeats,
    output logic [14:0] m_medium_repeats,
    output logic [14:0] m_low_repeats
);
    import bprg_pkg::*;

    bprg_item_t   in_item;
    bprg_result_t core_result;
    logic         consume;
    logic         out_free;

    // Input register: one item of buffering ahead of the core.
    bprg_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_image_byte (s_image_byte),
        .s_is_last    (s_is_last),
        .consume      (consume),
        .item         (in_item)
    );

    // Core: the three readings and their repeat counts.
    bprg_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (in_item),
        .out_free (out_free),
        .consume  (consume),
        .result   (core_result)
    );

    // Result register toward the receiver.
    bprg_out_stage u_out_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .result           (core_result),
        .out_free         (out_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_resolution     (m_resolution),
        .m_mono_repeats   (m_mono_repeats),
        .m_medium_repeats (m_medium_repeats),
        .m_low_repeats    (m_low_repeats)
    );

    // A new result only ever follows the consumption of a last item.
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_item.valid && in_item.is_last))
        else $error("result appeared without a last item");

    // The guess is always one of the three defined codes.
    a_resolution_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_resolution == RES_LOW || m_resolution == RES_MEDIUM ||
                     m_resolution == RES_MONO))
        else $error("undefined resolution code");

    // A mono guess means the mono count ties or beats both other counts.
    a_mono_wins: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_resolution == RES_MONO) |->
            (m_mono_repeats >= m_medium_repeats && m_mono_repeats >= m_low_repeats))
        else $error("mono guess without mono count winning");

endmodule

// ===== tb/tb_bitplane_resolution_guesser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitplane resolution guesser testbench
// Streams screen images into the guesser and checks each image's verdict.
// ----------------------------------------------------------------------------
// A queue of image bytes is filled up front: a few hand-built images that
// force each verdict, partial plane groups at the end of an image and single
// byte images, then random images of mixed length and content. A clocked
// driver feeds the queue to the input channel with random gaps, and a clocked
// monitor takes results with random stalls. Every byte the block accepts also
// runs through a local tally of the three readings; on the last byte of an
// image the predicted verdict is queued and later compared field by field
// with the result item that the block returns.
// ----------------------------------------------------------------------------
module tb_bitplane_resolution_guesser_top;

    import bprg_pkg::*;

    localparam int RANDOM_ITEMS   = 420;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // Content styles for random images.
    typedef enum logic [1:0] {
        FILL_NOISE,
        FILL_FEW,
        FILL_RUNS,
        FILL_TILED
    } fill_style_t;

    // One pending input item. A set hold flag makes the driver wait until
    // every verdict already owed has come back before it offers this item.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } pending_byte_t;

    typedef struct {
        logic [1:0] resolution;
        count_t     mono;
        count_t     med;
        count_t     low;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_image_byte = 8'h00;
    logic        s_is_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_resolution;
    logic [14:0] m_mono_repeats;
    logic [14:0] m_medium_repeats;
    logic [14:0] m_low_repeats;

    pending_byte_t byte_queue[$];
    verdict_t      owed_verdicts[$];

    // Local copy of the guesser's running state for the current image.
    logic [7:0]  prev_mono = 8'h00;
    logic [7:0]  prev_medium = 8'h00;
    logic [7:0]  prev_low = 8'h00;
    count_t      mono_n = '0;
    count_t      medium_n = '0;
    count_t      low_n = '0;
    logic [55:0] group_hist = '0;
    logic [2:0]  group_pos = 3'd0;

    int            total_bytes;
    int            bytes_accepted = 0;
    int            fail_count = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            send_quiet = 0;
    int            recv_stall = 0;
    int            recv_quiet = 0;
    int            recv_draw;
    bit            timed_out = 1'b0;
    pending_byte_t next_byte;
    verdict_t      got_want;

    bitplane_resolution_guesser_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_image_byte     (s_image_byte),
        .s_is_last        (s_is_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_resolution     (m_resolution),
        .m_mono_repeats   (m_mono_repeats),
        .m_medium_repeats (m_medium_repeats),
        .m_low_repeats    (m_low_repeats)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Repeat counts stop at their top value instead of wrapping.
    function automatic count_t bump(input count_t n);
        return (n == COUNT_MAX) ? n : n + 1'b1;
    endfunction

    // Fold one accepted byte into the three readings. The byte itself can
    // close a four- or eight-byte group, so groups are unpacked before any
    // verdict is formed.
    task automatic tally_image_byte(input logic [7:0] b, input logic last);
        logic [63:0] full;
        logic [7:0]  chunk;
        verdict_t    v;
        int          idx;
        full = {group_hist, b};

        if (b == prev_mono) begin
            mono_n = bump(mono_n);
        end else begin
            prev_mono = b;
        end

        // Two plane words: each chunky byte takes four pixels, plane one
        // in the upper bit of each pixel pair.
        if (group_pos == POS_MED_FIRST_END || group_pos == POS_GROUP_END) begin
            for (int c = 0; c < 4; c++) begin
                chunk = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    idx = 15 - 4 * c - k;
                    chunk = {chunk[5:0], full[16 + idx], full[idx]};
                end
                if (chunk == prev_medium) begin
                    medium_n = bump(medium_n);
                end else begin
                    prev_medium = chunk;
                end
            end
        end

        // Four plane words: each chunky byte takes two 4-bit pixels.
        if (group_pos == POS_GROUP_END) begin
            for (int c = 0; c < 8; c++) begin
                chunk = 8'h00;
                for (int k = 0; k < 2; k++) begin
                    idx = 15 - 2 * c - k;
                    chunk = {chunk[3:0], full[48 + idx], full[32 + idx],
                             full[16 + idx], full[idx]};
                end
                if (chunk == prev_low) begin
                    low_n = bump(low_n);
                end else begin
                    prev_low = chunk;
                end
            end
        end

        group_hist = full[55:0];
        group_pos = group_pos + 3'd1;

        if (last) begin
            if (mono_n >= low_n && mono_n >= medium_n) begin
                v.resolution = RES_MONO;
            end else if (medium_n > low_n) begin
                v.resolution = RES_MEDIUM;
            end else begin
                v.resolution = RES_LOW;
            end
            v.mono = mono_n;
            v.med = medium_n;
            v.low = low_n;
            owed_verdicts.push_back(v);

            // A fresh image starts from a clean slate, including the
            // position inside the plane group.
            prev_mono = 8'h00;
            prev_medium = 8'h00;
            prev_low = 8'h00;
            mono_n = '0;
            medium_n = '0;
            low_n = '0;
            group_hist = '0;
            group_pos = 3'd0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] data, input logic last, input bit hold);
        pending_byte_t p;
        p.data = data;
        p.last = last;
        p.hold = hold;
        byte_queue.push_back(p);
    endtask

    // Bytes from a tiny set make equal neighbors likely in every reading.
    function automatic logic [7:0] few_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h55;
            default: return 8'hAA;
        endcase
    endfunction

    task automatic queue_image(input fill_style_t style, input int len, input bit hold);
        logic [7:0] tile [8];
        logic [7:0] b;
        int         tile_len;
        int         run_left;
        tile_len = ($urandom_range(1) == 0) ? 4 : 8;
        foreach (tile[j]) begin
            tile[j] = ($urandom_range(1) == 0) ? 8'($urandom) : few_byte();
        end
        run_left = 0;
        b = 8'h00;
        for (int n = 0; n < len; n++) begin
            case (style)
                FILL_NOISE: b = 8'($urandom);
                FILL_FEW:   b = few_byte();
                FILL_RUNS: begin
                    if (run_left == 0) begin
                        b = 8'($urandom);
                        run_left = $urandom_range(6, 1);
                    end
                    run_left--;
                end
                default: begin
                    // A repeating tile lines up with the plane groups and
                    // gives the planar readings their repeats; a stray byte
                    // now and then breaks the pattern.
                    b = ($urandom_range(9) == 0) ? 8'($urandom) : tile[n % tile_len];
                end
            endcase
            queue_byte(b, n == len - 1, hold && n == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle pattern shared by both channels: mostly no gap, sometimes a few
    // cycles, rarely a long one.
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(3, 1);
        end else if (r < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // The sender now and then runs a streak of back-to-back items.
    function int next_send_gap();
        if (send_quiet > 0) begin
            send_quiet--;
            return 0;
        end
        if ($urandom_range(99) < 3) begin
            send_quiet = $urandom_range(120, 40);
            return 0;
        end
        return pick_gap();
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued bytes, and feeds each accepted one to the tally
    // at the same edge at which the block takes it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                tally_image_byte(s_image_byte, s_is_last);
                bytes_accepted++;
            end
            // The slot is free when nothing is offered or the offered item
            // has just been taken; otherwise valid and payload stay put.
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0 &&
                             !(byte_queue[0].hold && owed_verdicts.size() != 0)) begin
                    next_byte = byte_queue.pop_front();
                    s_valid <= 1'b1;
                    s_image_byte <= next_byte.data;
                    s_is_last <= next_byte.last;
                    send_gap = next_send_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stalls the result channel at random and checks each verdict
    // against the oldest one owed. It also keeps the watchdog's count of
    // cycles in which neither channel moved an item.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end

        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_verdicts.size() == 0) begin
                    $error("result item with no image pending");
                    fail_count++;
                end else begin
                    got_want = owed_verdicts.pop_front();
                    if (m_resolution !== got_want.resolution) begin
                        $error("resolution: expected %0d, actual %0d",
                               got_want.resolution, m_resolution);
                        fail_count++;
                    end
                    if (m_mono_repeats !== got_want.mono) begin
                        $error("mono_repeats: expected %0d, actual %0d",
                               got_want.mono, m_mono_repeats);
                        fail_count++;
                    end
                    if (m_medium_repeats !== got_want.med) begin
                        $error("medium_repeats: expected %0d, actual %0d",
                               got_want.med, m_medium_repeats);
                        fail_count++;
                    end
                    if (m_low_repeats !== got_want.low) begin
                        $error("low_repeats: expected %0d, actual %0d",
                               got_want.low, m_low_repeats);
                        fail_count++;
                    end
                end
            end

            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (recv_quiet > 0) begin
                recv_quiet--;
                m_ready <= 1'b1;
            end else begin
                recv_draw = $urandom_range(99);
                if (recv_draw < 2) begin
                    recv_quiet = $urandom_range(150, 30);
                    m_ready <= 1'b1;
                end else if (recv_draw < 20) begin
                    recv_stall = pick_gap();
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int random_bytes;
        int len;
        int r;

        // One zero byte: it equals the cleared mono history, so mono wins.
        queue_byte(8'h00, 1'b1, 1'b0);
        // One full byte: all counts stay at zero and the tie goes to mono.
        // The sender first waits for the previous verdict to come back.
        queue_byte(8'hFF, 1'b1, 1'b1);
        // One medium group whose plane words repeat pixel for pixel: the
        // two-plane reading finds two repeats, the others none.
        queue_byte(8'h55, 1'b0, 1'b0);
        queue_byte(8'hAA, 1'b0, 1'b0);
        queue_byte(8'h55, 1'b0, 1'b0);
        queue_byte(8'hAA, 1'b1, 1'b0);
        // One low group built from alternating plane halves: the four-plane
        // reading beats both mono and medium.
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        // Seven bytes: one medium group counts, the trailing partial medium
        // group and the unfinished low group do not.
        queue_byte(8'h12, 1'b0, 1'b0);
        queue_byte(8'h34, 1'b0, 1'b0);
        queue_byte(8'h56, 1'b0, 1'b0);
        queue_byte(8'h78, 1'b0, 1'b0);
        queue_byte(8'h9A, 1'b0, 1'b0);
        queue_byte(8'hBC, 1'b0, 1'b0);
        queue_byte(8'hDE, 1'b1, 1'b0);
        // A short image right after the odd-length one: its group position
        // must restart at zero.
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);

        // Random images, mostly short, a few long; some wait for the
        // pipeline to empty before they start.
        random_bytes = 0;
        while (random_bytes < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 70) begin
                len = $urandom_range(24, 1);
            end else if (r < 95) begin
                len = $urandom_range(80, 25);
            end else begin
                len = $urandom_range(200, 81);
            end
            queue_image(fill_style_t'($urandom_range(3)), len, $urandom_range(99) < 12);
            random_bytes += len;
        end
        total_bytes = byte_queue.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            begin
                while (bytes_accepted != total_bytes) @(posedge aclk);
                while (owed_verdicts.size() != 0) @(posedge aclk);
                // Leave room for any stray result item to show up.
                repeat (DRAIN_CYCLES) @(posedge aclk);
            end
            begin
                while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
